FILE: hdl/sitp_pkg.sv
package sitp_pkg;

    localparam logic [15:0] SKIP_RESET = 16'd2115;
    localparam int unsigned GAP_LEN    = 28;

    localparam logic [1:0] KIND_TITLE  = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_NO_QUOTE   = 2'd0;
    localparam logic [1:0] ERR_NOT_CLEAR  = 2'd1;
    localparam logic [1:0] ERR_BAD_GAP    = 2'd2;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef struct packed {
        logic [3:0]  field_index;
        logic        quote_seen;
        logic        quote_parity;
        logic        escape_pending;
        logic [31:0] page_acc;
        logic [15:0] space_acc;
        logic [7:0]  title_count;
        logic        gap_active;
        logic [4:0]  gap_match_pos;
        logic        halted;
    } parse_state_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  title_byte;
        logic [31:0] page_number;
        logic [15:0] name_space;
        logic [7:0]  title_length;
        logic [1:0]  error_code;
    } result_t;

    // Text that opens the next insert statement: "\nINSERT INTO `page` VALUES ("
    function automatic logic [7:0] gap_char(input logic [4:0] pos);
        logic [7:0] ch;
        unique case (pos)
            5'd0:    ch = 8'h0A;
            5'd1:    ch = 8'h49;
            5'd2:    ch = 8'h4E;
            5'd3:    ch = 8'h53;
            5'd4:    ch = 8'h45;
            5'd5:    ch = 8'h52;
            5'd6:    ch = 8'h54;
            5'd7:    ch = 8'h20;
            5'd8:    ch = 8'h49;
            5'd9:    ch = 8'h4E;
            5'd10:   ch = 8'h54;
            5'd11:   ch = 8'h4F;
            5'd12:   ch = 8'h20;
            5'd13:   ch = 8'h60;
            5'd14:   ch = 8'h70;
            5'd15:   ch = 8'h61;
            5'd16:   ch = 8'h67;
            5'd17:   ch = 8'h65;
            5'd18:   ch = 8'h60;
            5'd19:   ch = 8'h20;
            5'd20:   ch = 8'h56;
            5'd21:   ch = 8'h41;
            5'd22:   ch = 8'h4C;
            5'd23:   ch = 8'h55;
            5'd24:   ch = 8'h45;
            5'd25:   ch = 8'h53;
            5'd26:   ch = 8'h20;
            5'd27:   ch = 8'h28;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: hdl/sitp_step.sv
module sitp_step #(
    parameter int unsigned MAX_TITLE   = 255,
    parameter int unsigned FIELD_COUNT = 12
) (
    input  sitp_pkg::parse_state_t state_cur,
    input  logic [7:0]             data_byte,
    output sitp_pkg::parse_state_t state_nxt,
    output sitp_pkg::result_t      result
);

    localparam logic [3:0] FIELD_LAST = 4'(FIELD_COUNT - 1);
    localparam logic [3:0] FIELD_END  = 4'(FIELD_COUNT);
    localparam logic [7:0] TITLE_MAX  = 8'(MAX_TITLE);

    logic [3:0]  field_inc;
    logic [31:0] page_digit;
    logic [15:0] space_digit;
    logic [7:0]  title_inc;
    logic        is_comma;

    assign field_inc   = state_cur.field_index + 4'd1;
    assign page_digit  = {state_cur.page_acc[28:0], 3'b000} + {state_cur.page_acc[30:0], 1'b0}
                         + {24'd0, data_byte} - {24'd0, sitp_pkg::CH_ZERO};
    assign space_digit = {state_cur.space_acc[12:0], 3'b000}
                         + {state_cur.space_acc[14:0], 1'b0}
                         + {8'd0, data_byte} - {8'd0, sitp_pkg::CH_ZERO};
    assign title_inc   = (state_cur.title_count < TITLE_MAX) ? state_cur.title_count + 8'd1
                                                             : state_cur.title_count;
    assign is_comma    = (data_byte == sitp_pkg::CH_COMMA)
                         && !(state_cur.field_index == 4'd2 && state_cur.quote_parity);

    always_comb
    begin
        state_nxt = state_cur;
        result    = '0;
        if (state_cur.halted)
        begin
            state_nxt = state_cur;
        end
        else if (is_comma)
        begin
            if (field_inc >= FIELD_END && state_cur.page_acc != 32'd0)
            begin
                state_nxt.field_index = field_inc;
                state_nxt.halted      = 1'b1;
                result.valid          = 1'b1;
                result.kind           = sitp_pkg::KIND_ERROR;
                result.error_code     = sitp_pkg::ERR_NOT_CLEAR;
            end
            else
            begin
                state_nxt.field_index  = (field_inc >= FIELD_END) ? 4'd0 : field_inc;
                state_nxt.quote_seen   = 1'b0;
                state_nxt.quote_parity = 1'b0;
            end
        end
        else if (state_cur.field_index == 4'd0)
        begin
            if (data_byte != sitp_pkg::CH_LPAREN)
            begin
                state_nxt.page_acc = page_digit;
            end
        end
        else if (state_cur.field_index == 4'd1)
        begin
            state_nxt.space_acc = space_digit;
        end
        else if (state_cur.field_index == 4'd2)
        begin
            if (!state_cur.quote_seen)
            begin
                if (data_byte != sitp_pkg::CH_QUOTE)
                begin
                    state_nxt.halted  = 1'b1;
                    result.valid      = 1'b1;
                    result.kind       = sitp_pkg::KIND_ERROR;
                    result.error_code = sitp_pkg::ERR_NO_QUOTE;
                end
                else
                begin
                    state_nxt.escape_pending = 1'b0;
                    state_nxt.quote_seen     = 1'b1;
                    state_nxt.quote_parity   = 1'b1;
                end
            end
            else if (data_byte == sitp_pkg::CH_QUOTE && !state_cur.escape_pending)
            begin
                state_nxt.quote_parity = !state_cur.quote_parity;
                // doubled quote inside the title
                if (!state_cur.quote_parity)
                begin
                    state_nxt.title_count = title_inc;
                    result.valid          = 1'b1;
                    result.kind           = sitp_pkg::KIND_TITLE;
                    result.title_byte     = sitp_pkg::CH_QUOTE;
                end
            end
            else if (data_byte == sitp_pkg::CH_BSLASH && !state_cur.escape_pending)
            begin
                state_nxt.escape_pending = 1'b1;
            end
            else
            begin
                state_nxt.escape_pending = 1'b0;
                state_nxt.title_count    = title_inc;
                result.valid             = 1'b1;
                result.kind              = sitp_pkg::KIND_TITLE;
                result.title_byte        = data_byte;
            end
        end
        else if (state_cur.field_index == FIELD_LAST)
        begin
            if (data_byte == sitp_pkg::CH_RPAREN)
            begin
                result.valid          = 1'b1;
                result.kind           = sitp_pkg::KIND_RECORD;
                result.page_number    = state_cur.page_acc;
                result.name_space     = state_cur.space_acc;
                result.title_length   = state_cur.title_count;
                state_nxt.page_acc    = 32'd0;
                state_nxt.space_acc   = 16'd0;
                state_nxt.title_count = 8'd0;
            end
            else if (data_byte == sitp_pkg::CH_SEMI)
            begin
                state_nxt.gap_active    = 1'b1;
                state_nxt.gap_match_pos = 5'd0;
            end
            else if (state_cur.gap_active)
            begin
                if (state_cur.gap_match_pos < 5'(sitp_pkg::GAP_LEN)
                    && data_byte == sitp_pkg::gap_char(state_cur.gap_match_pos))
                begin
                    state_nxt.gap_match_pos = state_cur.gap_match_pos + 5'd1;
                    if (data_byte == sitp_pkg::CH_LPAREN)
                    begin
                        state_nxt.gap_active    = 1'b0;
                        state_nxt.gap_match_pos = 5'd0;
                        state_nxt.field_index   = 4'd0;
                        state_nxt.quote_seen    = 1'b0;
                        state_nxt.quote_parity  = 1'b0;
                    end
                end
                else if (data_byte == sitp_pkg::CH_SLASH)
                begin
                    state_nxt.halted = 1'b1;
                    result.valid     = 1'b1;
                    result.kind      = sitp_pkg::KIND_END;
                end
                else
                begin
                    state_nxt.halted  = 1'b1;
                    result.valid      = 1'b1;
                    result.kind       = sitp_pkg::KIND_ERROR;
                    result.error_code = sitp_pkg::ERR_BAD_GAP;
                end
            end
        end
    end

endmodule

FILE: hdl/sql_insert_tuple_parser_core.sv
// A byte accepted into byte_reg is parsed when it advances; its result beat is then
// registered in out_reg. Throughput: one byte per cycle while out_ready holds no
// result beat stalled; the parse state update loops through state_reg alone.
// Reset (rst_n, async, active low) clears the parse state, reloads the header skip
// count to 2115 and empties both register stages.
module sql_insert_tuple_parser_core #(
    parameter int unsigned MAX_TITLE   = 255,
    parameter int unsigned FIELD_COUNT = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] header_skip,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  title_byte,
    output logic [31:0] page_number,
    output logic [15:0] name_space,
    output logic [7:0]  title_length,
    output logic [1:0]  error_code
);

    sitp_pkg::parse_state_t state_reg, state_next, step_state;
    sitp_pkg::result_t      step_result;
    sitp_pkg::result_t      out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   byte_valid_reg, byte_valid_next;
    logic [7:0]             byte_reg, byte_next;
    logic [15:0]            skip_left_reg, skip_left_next;
    logic                   advance;
    logic                   parse_en;

    sitp_step #(
        .MAX_TITLE   (MAX_TITLE),
        .FIELD_COUNT (FIELD_COUNT)
    ) u_step (
        .state_cur (state_reg),
        .data_byte (byte_reg),
        .state_nxt (step_state),
        .result    (step_result)
    );

    assign advance   = byte_valid_reg && (!out_valid_reg || out_ready);
    assign parse_en  = advance && !state_reg.halted && (skip_left_reg == 16'd0);
    assign in_ready  = !byte_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        byte_next       = byte_reg;
        if (in_valid && in_ready)
        begin
            byte_valid_next = 1'b1;
            byte_next       = data_byte;
        end
        else if (advance)
        begin
            byte_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        skip_left_next = skip_left_reg;
        state_next     = state_reg;
        if (cfg_valid && cfg_ready)
        begin
            skip_left_next = header_skip;
        end
        else if (advance && !state_reg.halted && skip_left_reg != 16'd0)
        begin
            skip_left_next = skip_left_reg - 16'd1;
        end
        if (parse_en)
        begin
            state_next = step_state;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = parse_en && step_result.valid;
            out_next       = step_result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            skip_left_reg  <= sitp_pkg::SKIP_RESET;
            state_reg      <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            out_valid_reg  <= out_valid_next;
            skip_left_reg  <= skip_left_next;
            state_reg      <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        out_reg  <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign title_byte   = out_reg.title_byte;
    assign page_number  = out_reg.page_number;
    assign name_space   = out_reg.name_space;
    assign title_length = out_reg.title_length;
    assign error_code   = out_reg.error_code;

endmodule

FILE: hdl/sitp_checker.sv
module sitp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  title_byte,
    input logic [31:0] page_number,
    input logic [15:0] name_space,
    input logic [7:0]  title_length,
    input logic [1:0]  error_code
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(error_code))
    else $error("result beat changed while stalled");

    // end of dump or error halts the parser: nothing follows
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready
        && (kind == sitp_pkg::KIND_END || kind == sitp_pkg::KIND_ERROR) |=> !out_valid)
    else $error("result beat after halt");

    // record fields are zero on other beats
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != sitp_pkg::KIND_RECORD
        |-> page_number == 32'd0 && name_space == 16'd0 && title_length == 8'd0)
    else $error("record fields set on a non-record beat");

    // title byte and error code only on their own beats
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == sitp_pkg::KIND_TITLE || title_byte == 8'd0)
                   && (kind == sitp_pkg::KIND_ERROR || error_code == 2'd0)
                   && error_code != 2'd3)
    else $error("field set on wrong beat kind");

endmodule

bind sql_insert_tuple_parser_core sitp_checker u_sitp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .title_byte   (title_byte),
    .page_number  (page_number),
    .name_space   (name_space),
    .title_length (title_length),
    .error_code   (error_code)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned MAX_TITLE   = 255;
    localparam int unsigned FIELD_COUNT = 12;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  title_byte;
        logic [31:0] page_number;
        logic [15:0] name_space;
        logic [7:0]  title_length;
        logic [1:0]  error_code;
    } beat_t;

    typedef enum int {STOP_END, STOP_BAD_GAP, STOP_NO_QUOTE, STOP_NOT_CLEAR} stop_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [15:0] header_skip = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte   = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  title_byte;
    logic [31:0] page_number;
    logic [15:0] name_space;
    logic [7:0]  title_length;
    logic [1:0]  error_code;

    // "\nINSERT INTO `page` VALUES ("
    logic [7:0] gap_txt [sitp_pkg::GAP_LEN] = '{8'h0A, "I", "N", "S", "E", "R", "T", " ",
        "I", "N", "T", "O", " ", 8'h60, "p", "a", "g", "e", 8'h60, " ", "V", "A", "L",
        "U", "E", "S", " ", "("};

    logic [7:0] feed_q [$];
    beat_t      due_beats [$];
    int         pushed_n   = 0;
    int         accepted_n = 0;
    int         mismatches = 0;
    logic       in_taken   = 1'b0;
    logic       cfg_taken  = 1'b0;
    logic       calm       = 1'b0;

    // parser state kept by the testbench
    logic [15:0] skip_setting = sitp_pkg::SKIP_RESET;
    logic [15:0] skip_left    = sitp_pkg::SKIP_RESET;
    logic [3:0]  field_idx    = '0;
    logic        q_seen       = 1'b0;
    logic        q_odd        = 1'b0;
    logic        esc_pend     = 1'b0;
    logic [31:0] page_acc     = '0;
    logic [15:0] space_acc    = '0;
    logic [7:0]  title_cnt    = '0;
    logic        gap_on       = 1'b0;
    logic [4:0]  gap_pos      = '0;
    logic        halted       = 1'b0;

    sql_insert_tuple_parser_core #(
        .MAX_TITLE   (MAX_TITLE),
        .FIELD_COUNT (FIELD_COUNT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .header_skip  (header_skip),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .title_byte   (title_byte),
        .page_number  (page_number),
        .name_space   (name_space),
        .title_length (title_length),
        .error_code   (error_code)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit parse_dump_byte(input logic [7:0] c, output beat_t b);
        b = '0;
        if (halted)
            return 0;
        if (skip_left != 0)
        begin
            skip_left--;
            return 0;
        end
        if (c == sitp_pkg::CH_COMMA && !(field_idx == 2 && q_odd))
        begin
            field_idx++;
            if (field_idx >= FIELD_COUNT)
            begin
                if (page_acc != 0)
                begin
                    halted       = 1'b1;
                    b.kind       = sitp_pkg::KIND_ERROR;
                    b.error_code = sitp_pkg::ERR_NOT_CLEAR;
                    return 1;
                end
                field_idx = 4'd0;
            end
            q_seen = 1'b0;
            q_odd  = 1'b0;
            return 0;
        end
        if (field_idx == 0)
        begin
            if (c != sitp_pkg::CH_LPAREN)
                page_acc = page_acc * 32'd10 + c - sitp_pkg::CH_ZERO;
            return 0;
        end
        if (field_idx == 1)
        begin
            space_acc = space_acc * 16'd10 + c - sitp_pkg::CH_ZERO;
            return 0;
        end
        if (field_idx == 2)
        begin
            if (!q_seen)
            begin
                if (c != sitp_pkg::CH_QUOTE)
                begin
                    halted       = 1'b1;
                    b.kind       = sitp_pkg::KIND_ERROR;
                    b.error_code = sitp_pkg::ERR_NO_QUOTE;
                    return 1;
                end
                esc_pend = 1'b0;
                q_seen   = 1'b1;
                q_odd    = 1'b1;
                return 0;
            end
            if (c == sitp_pkg::CH_QUOTE && !esc_pend)
            begin
                q_odd = !q_odd;
                if (!q_odd)
                    return 0;
            end
            else if (c == sitp_pkg::CH_BSLASH && !esc_pend)
            begin
                esc_pend = 1'b1;
                return 0;
            end
            else
                esc_pend = 1'b0;
            if (title_cnt < MAX_TITLE)
                title_cnt++;
            b.kind       = sitp_pkg::KIND_TITLE;
            b.title_byte = c;
            return 1;
        end
        if (field_idx == FIELD_COUNT - 1)
        begin
            if (c == sitp_pkg::CH_RPAREN)
            begin
                b.kind         = sitp_pkg::KIND_RECORD;
                b.page_number  = page_acc;
                b.name_space   = space_acc;
                b.title_length = title_cnt;
                page_acc  = '0;
                space_acc = '0;
                title_cnt = '0;
                return 1;
            end
            if (c == sitp_pkg::CH_SEMI)
            begin
                gap_on  = 1'b1;
                gap_pos = '0;
                return 0;
            end
            if (gap_on)
            begin
                if (gap_pos < sitp_pkg::GAP_LEN && c == gap_txt[gap_pos])
                begin
                    gap_pos++;
                    if (c == sitp_pkg::CH_LPAREN)
                    begin
                        gap_on    = 1'b0;
                        gap_pos   = '0;
                        field_idx = 4'd0;
                        q_seen    = 1'b0;
                        q_odd     = 1'b0;
                    end
                    return 0;
                end
                halted = 1'b1;
                if (c == sitp_pkg::CH_SLASH)
                    b.kind = sitp_pkg::KIND_END;
                else
                begin
                    b.kind       = sitp_pkg::KIND_ERROR;
                    b.error_code = sitp_pkg::ERR_BAD_GAP;
                end
                return 1;
            end
        end
        return 0;
    endfunction

    // driver
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 12);
        if (!in_valid || in_taken)
        begin
            if (feed_q.size() != 0 && (calm || $urandom_range(0, 99) >= 12))
            begin
                data_byte <= feed_q.pop_front();
                in_valid  <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        beat_t want;
        beat_t seen;
        in_taken  <= in_valid && in_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                skip_setting = header_skip;
                skip_left    = skip_setting;
            end
            if (in_valid && in_ready)
            begin
                accepted_n++;
                if (parse_dump_byte(data_byte, want))
                    due_beats.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                seen = '{kind, title_byte, page_number, name_space, title_length, error_code};
                if (due_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: kind %0d tb %h pg %h ns %h tl %0d ec %0d",
                                 seen.kind, seen.title_byte, seen.page_number,
                                 seen.name_space, seen.title_length, seen.error_code);
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (seen.kind !== want.kind || seen.title_byte !== want.title_byte ||
                        seen.page_number !== want.page_number ||
                        seen.name_space !== want.name_space ||
                        seen.title_length !== want.title_length ||
                        seen.error_code !== want.error_code)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"beat mismatch: exp kind %0d tb %h pg %h ns %h tl %0d",
                                      " ec %0d / got kind %0d tb %h pg %h ns %h tl %0d ec %0d"},
                                     want.kind, want.title_byte, want.page_number,
                                     want.name_space, want.title_length, want.error_code,
                                     seen.kind, seen.title_byte, seen.page_number,
                                     seen.name_space, seen.title_length, seen.error_code);
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] c);
        feed_q.push_back(c);
        pushed_n++;
    endtask

    task automatic push_str(input string s);
        for (int k = 0; k < s.len(); k++)
            push_byte(s[k]);
    endtask

    task automatic push_filler(input int n);
        repeat (n) push_byte(8'($urandom));
    endtask

    task automatic push_noise(input int n, input bit last);
        logic [7:0] c;
        for (int k = 0; k < n; k++)
        begin
            do
                c = 8'($urandom);
            while (c == sitp_pkg::CH_COMMA
                   || (last && (c == sitp_pkg::CH_RPAREN || c == sitp_pkg::CH_SEMI)));
            push_byte(c);
        end
    endtask

    task automatic push_digits(input int n);
        repeat (n) push_byte(sitp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_gap(input int n);
        for (int k = 0; k < n; k++)
            push_byte(gap_txt[k]);
    endtask

    // fields 3..11, empty except for the last one
    task automatic push_rest(input string last_field, input bit close);
        repeat (FIELD_COUNT - 3) push_byte(sitp_pkg::CH_COMMA);
        push_str(last_field);
        if (close)
            push_byte(sitp_pkg::CH_RPAREN);
    endtask

    task automatic push_title(input int len);
        logic [7:0] c;
        int         r;
        push_byte(sitp_pkg::CH_QUOTE);
        for (int k = 0; k < len; k++)
        begin
            c = 8'($urandom);
            r = $urandom_range(0, 15);
            if (r == 0)
                c = sitp_pkg::CH_QUOTE;
            else if (r == 1)
                c = sitp_pkg::CH_BSLASH;
            if (c == sitp_pkg::CH_QUOTE)
            begin
                push_byte($urandom_range(0, 1) ? sitp_pkg::CH_QUOTE : sitp_pkg::CH_BSLASH);
                push_byte(sitp_pkg::CH_QUOTE);
            end
            else if (c == sitp_pkg::CH_BSLASH)
            begin
                push_byte(sitp_pkg::CH_BSLASH);
                push_byte(sitp_pkg::CH_BSLASH);
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    push_byte(sitp_pkg::CH_BSLASH);
                push_byte(c);
            end
        end
        push_byte(sitp_pkg::CH_QUOTE);
        // stray text after the closing quote still counts as title
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
            begin
                do
                    c = 8'($urandom);
                while (c == sitp_pkg::CH_COMMA || c == sitp_pkg::CH_QUOTE
                       || c == sitp_pkg::CH_BSLASH);
                push_byte(c);
            end
    endtask

    task automatic push_tuple();
        push_byte(sitp_pkg::CH_LPAREN);
        if ($urandom_range(0, 7) == 0)
            push_noise($urandom_range(0, 4), 1'b0);
        else
            push_digits($urandom_range(1, 10));
        push_byte(sitp_pkg::CH_COMMA);
        if ($urandom_range(0, 7) == 0)
            push_noise($urandom_range(0, 3), 1'b0);
        else
            push_digits($urandom_range(1, 5));
        push_byte(sitp_pkg::CH_COMMA);
        push_title(($urandom_range(0, 39) == 0) ? $urandom_range(250, 300)
                                                : $urandom_range(0, 20));
        for (int f = 3; f < FIELD_COUNT; f++)
        begin
            push_byte(sitp_pkg::CH_COMMA);
            push_noise($urandom_range(0, 3), f == FIELD_COUNT - 1);
        end
        push_byte(sitp_pkg::CH_RPAREN);
    endtask

    task automatic push_separator();
        int cut;
        if ($urandom_range(0, 3) != 0)
            push_byte(sitp_pkg::CH_COMMA);
        else
        begin
            push_byte(sitp_pkg::CH_SEMI);
            if ($urandom_range(0, 2) == 0)
            begin
                push_gap($urandom_range(0, sitp_pkg::GAP_LEN - 1));
                push_byte(sitp_pkg::CH_SEMI);
            end
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sitp_pkg::GAP_LEN - 1) : -1;
            for (int k = 0; k < sitp_pkg::GAP_LEN; k++)
            begin
                if (k == cut)
                    push_byte(sitp_pkg::CH_RPAREN);
                push_byte(gap_txt[k]);
            end
        end
    endtask

    task automatic push_tuples(input int n);
        int goal;
        goal = pushed_n + n;
        while (pushed_n < goal)
        begin
            push_separator();
            push_tuple();
        end
    endtask

    task automatic settle();
        while (accepted_n != pushed_n || due_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_skip(input logic [15:0] v);
        @(negedge clk);
        header_skip <= v;
        cfg_valid   <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input logic [15:0] v);
        settle();
        write_skip(v);
        push_filler(int'(v));
    endtask

    initial
    begin
        stop_t how;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // part of the reset skip, then a shorter skip reloaded over it
        push_filler(30);
        start_phase(16'd24);
        push_str("(4294967295,65535,'a''b\\'c\\\\d\\n,e'");
        push_rest("z", 1'b1);
        push_str(",(4294967296,65536,''");
        push_rest("", 1'b1);
        push_str(",(");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(sitp_pkg::CH_COMMA);
        push_byte(8'hFF);
        push_str(",'");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_str("'x");
        push_rest("q", 1'b1);
        push_byte(sitp_pkg::CH_RPAREN);
        push_byte(sitp_pkg::CH_SEMI);
        push_gap(4);
        push_byte(sitp_pkg::CH_SEMI);
        push_byte(sitp_pkg::CH_RPAREN);
        push_gap(sitp_pkg::GAP_LEN);
        push_str("(12,3,'T'");
        push_rest("", 1'b1);
        push_tuples(180);

        settle();
        calm = 1'b1;
        write_skip(16'd0);
        push_tuples(280);
        settle();
        calm = 1'b0;

        // widest skip, cut short by the next write
        settle();
        write_skip(16'hFFFF);
        push_filler(40);
        start_phase(16'($urandom_range(1, 40)));
        push_tuples(180);
        start_phase(16'($urandom_range(0, 60)));
        push_tuples(150);

        how = stop_t'($urandom_range(0, 3));
        case (how)
            STOP_END:
                push_str(";\n/");
            STOP_BAD_GAP:
                push_str(";\nINQ");
            STOP_NO_QUOTE:
                push_str(",(5,0,Q");
            STOP_NOT_CLEAR:
            begin
                push_str(",(5,0,'t'");
                push_rest("", 1'b0);
                push_byte(sitp_pkg::CH_COMMA);
            end
        endcase
        push_filler(20);

        settle();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && due_beats.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
